@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Screen geometry, cell constants, mode codes and helpers for the
// text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 24;
    localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;

    // internal widths
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);

    // item field widths
    localparam int MODE_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int CELL_ADR_W = 11;
    localparam int CURSOR_W   = 11;
    localparam int CELL_W     = 16;
    localparam int PROMPT_W   = 7;

    // cell constants
    localparam logic [CHAR_W-1:0]   BLANK_CHAR   = 8'h20;
    localparam logic [COLOR_W-1:0]  GREEN_ATTR   = 8'h02;
    localparam logic [CELL_W-1:0]   BLANK_CELL   = {GREEN_ATTR, BLANK_CHAR};
    localparam logic [PROMPT_W-1:0] PROMPT_RESET = 7'd8;

    // command modes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUT_CHAR  = 3'd0,
        MODE_DELETE    = 3'd1,
        MODE_NEWLINE   = 3'd2,
        MODE_SET_COLOR = 3'd3,
        MODE_READ_CELL = 3'd4
    } mode_t;

    // linear cell index of a row and column
    function automatic logic [ADDR_W-1:0] cell_index(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [ADDR_W-1:0] base;
        begin
            base = ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS));
            cell_index = ADDR_W'(base + ADDR_W'(col));
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen cell memory, cursor, current color.
// ----------------------------------------------------------------------------
// For put char, delete, newline and set color items, the cell write and
// the cursor update happen at the edge that accepts the item and the result
// is registered then. A read cell item first loads the registered read data
// of the single-port screen memory, then state ST_READ registers the result.
// After reset, and after any put char or newline that runs past the last
// row, the block runs a clearing pass over SCREEN_ROWS*SCREEN_COLUMNS cells
// (1920 at 80x24), one cell per cycle, and accepts no item during it; the
// result of the item that started the wrap is already available (cursor
// home). prompt_length writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,   // prompt_length
    // command items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // char_code[7:0], new_color[15:8],
                                          // cell_address[26:16]
    input  wire logic [2:0]  s_tuser,     // mode[2:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata      // cursor_location[10:0], cell_data[26:11]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CLEAR
    } state_t;

    // input fields
    logic [tcw_pkg::MODE_W-1:0]     in_mode;
    logic [tcw_pkg::CHAR_W-1:0]     in_char;
    logic [tcw_pkg::COLOR_W-1:0]    in_color;
    logic [tcw_pkg::CELL_ADR_W-1:0] in_addr;
    logic                           in_accept;
    logic                           in_addr_oob;

    // registers
    state_t                         state_reg, state_next;
    logic [tcw_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0]      col_reg, col_next;
    logic [tcw_pkg::COLOR_W-1:0]    color_reg, color_next;
    logic [tcw_pkg::PROMPT_W-1:0]   prompt_reg;
    logic [tcw_pkg::ADDR_W-1:0]     clear_addr_reg, clear_addr_next;
    logic                           rd_oob_reg, rd_oob_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [tcw_pkg::CURSOR_W-1:0]   out_cursor_reg, out_cursor_next;
    logic [tcw_pkg::CELL_W-1:0]     out_cell_reg, out_cell_next;

    // memory port
    logic [tcw_pkg::CELL_W-1:0]     screen_mem [tcw_pkg::CELL_COUNT];
    logic [tcw_pkg::CELL_W-1:0]     rd_data_reg;
    logic                           mem_we;
    logic [tcw_pkg::ADDR_W-1:0]     mem_addr;
    logic [tcw_pkg::CELL_W-1:0]     mem_wdata;

    // helpers
    logic [tcw_pkg::COL_W-1:0]      del_col;
    logic                           last_col;
    logic                           last_row;
    logic                           wrap;

    assign in_mode  = s_tuser;
    assign in_char  = s_tdata[7:0];
    assign in_color = s_tdata[15:8];
    assign in_addr  = s_tdata[26:16];

    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;

    assign in_addr_oob = int'(in_addr) >= tcw_pkg::CELL_COUNT;
    assign last_col    = col_reg == tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1);
    assign last_row    = row_reg == tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);

    // delete steps back only while right of the prompt
    assign del_col = (int'(col_reg) > int'(prompt_reg)) ?
                     tcw_pkg::COL_W'(col_reg - 1'b1) : col_reg;

    // next-state and memory port logic
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        color_next      = color_reg;
        clear_addr_next = clear_addr_reg;
        rd_oob_next     = rd_oob_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_cursor_next = out_cursor_reg;
        out_cell_next   = out_cell_reg;
        mem_we          = 1'b0;
        mem_addr        = tcw_pkg::cell_index(row_reg, col_reg);
        mem_wdata       = {color_reg, in_char};
        wrap            = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we          = 1'b1;
                mem_addr        = clear_addr_reg;
                mem_wdata       = tcw_pkg::BLANK_CELL;
                clear_addr_next = tcw_pkg::ADDR_W'(clear_addr_reg + 1'b1);
                if (clear_addr_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                m_tvalid_next   = 1'b1;
                out_cursor_next = tcw_pkg::CURSOR_W'(tcw_pkg::cell_index(row_reg, col_reg));
                out_cell_next   = rd_oob_reg ? '0 : rd_data_reg;
                state_next      = ST_IDLE;
            end
            default:
            begin
                if (in_accept)
                begin
                    case (tcw_pkg::mode_t'(in_mode))
                        tcw_pkg::MODE_PUT_CHAR:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {color_reg, in_char};
                            if (last_col)
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    wrap = 1'b1;
                                end
                                else
                                begin
                                    row_next = tcw_pkg::ROW_W'(row_reg + 1'b1);
                                end
                            end
                            else
                            begin
                                col_next = tcw_pkg::COL_W'(col_reg + 1'b1);
                            end
                        end
                        tcw_pkg::MODE_DELETE:
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = tcw_pkg::cell_index(row_reg, del_col);
                            mem_wdata = {color_reg, tcw_pkg::BLANK_CHAR};
                            col_next  = del_col;
                        end
                        tcw_pkg::MODE_NEWLINE:
                        begin
                            col_next = '0;
                            if (last_row)
                            begin
                                wrap = 1'b1;
                            end
                            else
                            begin
                                row_next = tcw_pkg::ROW_W'(row_reg + 1'b1);
                            end
                        end
                        tcw_pkg::MODE_SET_COLOR:
                        begin
                            color_next = in_color;
                        end
                        tcw_pkg::MODE_READ_CELL:
                        begin
                            mem_addr    = in_addr_oob ? '0 : tcw_pkg::ADDR_W'(in_addr);
                            rd_oob_next = in_addr_oob;
                            state_next  = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase

                    // screen wrap: home, green, then sweep the memory
                    if (wrap)
                    begin
                        row_next        = '0;
                        col_next        = '0;
                        color_next      = tcw_pkg::GREEN_ATTR;
                        clear_addr_next = '0;
                        state_next      = ST_CLEAR;
                    end

                    // every mode but read cell answers at once
                    if (in_mode != tcw_pkg::MODE_READ_CELL)
                    begin
                        m_tvalid_next   = 1'b1;
                        out_cell_next   = '0;
                        out_cursor_next = tcw_pkg::CURSOR_W'(
                                              tcw_pkg::cell_index(row_next, col_next));
                    end
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            row_reg        <= '0;
            col_reg        <= '0;
            color_reg      <= tcw_pkg::GREEN_ATTR;
            prompt_reg     <= tcw_pkg::PROMPT_RESET;
            clear_addr_reg <= '0;
            rd_oob_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            out_cursor_reg <= '0;
            out_cell_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            color_reg      <= color_next;
            clear_addr_reg <= clear_addr_next;
            rd_oob_reg     <= rd_oob_next;
            m_tvalid_reg   <= m_tvalid_next;
            out_cursor_reg <= out_cursor_next;
            out_cell_reg   <= out_cell_next;
            if (cfg_we)
            begin
                prompt_reg <= cfg_wdata;
            end
        end
    end

    // screen memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_addr] <= mem_wdata;
        end
        else
        begin
            rd_data_reg <= screen_mem[mem_addr];
        end
    end

    // result item
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_cell_reg, out_cursor_reg};

    // no item taken while the screen is being cleared or a read is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("item accepted outside idle");

    // cursor always stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(row_reg) < tcw_pkg::SCREEN_ROWS) &&
        (int'(col_reg) < tcw_pkg::SCREEN_COLUMNS))
        else $error("cursor off screen");

    // the read slot is never taken by a write
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !mem_we)
        else $error("memory write during pending read");

    // a read cell item moves to ST_READ in the next cycle, with no result valid yet
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_mode == tcw_pkg::MODE_READ_CELL)) |=>
        (state_reg == ST_READ) && !m_tvalid_reg)
        else $error("read cell sequencing broken");

    // a wrap homes the cursor and starts the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && wrap) |=>
        (state_reg == ST_CLEAR) && (clear_addr_reg == '0) && (out_cursor_reg == '0))
        else $error("screen wrap did not restart clearing");

endmodule

`default_nettype wire
